// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compensation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and fixed-point helpers of the pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned DIV_STAGES  = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned BACK_STAGES = 1 + DIV_STAGES + 7 + DIV_STAGES + 2;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_K3     = 32'd3791;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_coef;

    // One queued item: temperature term X1, divisor X1+MD and the raw pressure.
    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] den;
        logic [18:0] up;
    } t_fq;

    typedef struct packed {
        logic        push;
        t_fq         item;
    } t_fq_wr;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] zx16(input logic [15:0] v);
        return {16'd0, v};
    endfunction

    // Product modulo 2^32; the low half does not depend on signedness.
    function automatic logic [31:0] wmul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] p;
        p = a * b;
        return p;
    endfunction

    // Signed division by 2^k that truncates toward zero.
    function automatic logic [31:0] sdiv_p2(input logic [31:0] v, input int unsigned k);
        logic [31:0] bias;
        logic [31:0] s;
        bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        s    = v + bias;
        return 32'($signed(s) >>> k);
    endfunction

    function automatic logic [15:0] clamp_t(input logic [31:0] v);
        logic [15:0] r;
        if ($signed(v) < -32'sd32768) begin
            r = 16'h8000;
        end else if ($signed(v) > 32'sd32767) begin
            r = 16'h7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [20:0] clamp_p(input logic [31:0] v);
        logic [20:0] r;
        if ($signed(v) < -32'sd1048576) begin
            r = 21'h10_0000;
        end else if ($signed(v) > 32'sd1048575) begin
            r = 21'h0F_FFFF;
        end else begin
            r = v[20:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring unsigned 32-bit divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);

    logic [31:0] r_rem [bpc_pkg::DIV_STAGES];
    logic [31:0] r_quo [bpc_pkg::DIV_STAGES];
    logic [31:0] r_num [bpc_pkg::DIV_STAGES];
    logic [31:0] r_den [bpc_pkg::DIV_STAGES];

    for (genvar g = 0; g < bpc_pkg::DIV_STAGES; g++) begin : g_st
        logic [31:0] w_rem;
        logic [31:0] w_num;
        logic [31:0] w_den;
        logic [31:0] w_quo;
        logic [32:0] w_sh;
        logic [32:0] w_dif;

        if (g == 0) begin : g_first
            assign w_rem = 32'd0;
            assign w_num = i_num;
            assign w_den = i_den;
            assign w_quo = 32'd0;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_num = r_num[g-1];
            assign w_den = r_den[g-1];
            assign w_quo = r_quo[g-1];
        end

        assign w_sh  = {w_rem, w_num[bpc_pkg::DIV_STAGES-1-g]};
        assign w_dif = w_sh - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_dif[32] ? w_sh[31:0] : w_dif[31:0];
                r_quo[g] <= {w_quo[30:0], ~w_dif[32]};
                r_num[g] <= w_num;
                r_den[g] <= w_den;
            end
        end
    end

    assign o_quo = r_quo[bpc_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/bpc_queue.sv =====
// ----------------------------------------------------------------------------
// bpc_queue
// Short register queue between the front and the back part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpc_pkg::t_fq_wr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bpc_pkg::t_fq   o_head
);

    bpc_pkg::t_fq                  r_mem [bpc_pkg::QUEUE_DEPTH];
    logic [bpc_pkg::QPTR_W-1:0]    r_wr;
    logic [bpc_pkg::QPTR_W-1:0]    r_rd;
    logic [bpc_pkg::QPTR_W:0]      r_cnt;
    logic [bpc_pkg::QPTR_W:0]      n_cnt;

    assign o_full  = (r_cnt == (bpc_pkg::QPTR_W+1)'(bpc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr.push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr.push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr] <= i_wr.item;
        end
    end

    `CHK_SAME(a_q_bound, 1'b1, r_cnt <= (bpc_pkg::QPTR_W+1)'(bpc_pkg::QUEUE_DEPTH), "queue overfilled")
    `CHK_SAME(a_q_pop, i_pop, r_cnt != '0, "pop from empty queue")
    `CHK_SAME(a_q_push, i_wr.push, !o_full, "push into full queue")

endmodule

// ===== rtl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Calibration registers, reading intake and the first temperature terms.
// ----------------------------------------------------------------------------
module bpc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [39:0]      i_s_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
    input  logic             i_q_full,
    output bpc_pkg::t_fq_wr  o_q_wr,
    output bpc_pkg::t_coef   o_coef
);

    bpc_pkg::t_coef r_coef;
    logic           r_f_v;
    logic [31:0]    r_prod;
    logic [18:0]    r_up;
    logic [16:0]    w_diff;
    logic [33:0]    w_prod;
    logic [31:0]    w_x1;
    logic           w_take;

    assign o_cfg_ready = 1'b1;
    assign o_coef      = r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpc_pkg::REG_AC1_AC2: begin
                    r_coef.ac1 <= i_cfg_data[31:16];
                    r_coef.ac2 <= i_cfg_data[15:0];
                end
                bpc_pkg::REG_AC3_AC4: begin
                    r_coef.ac3 <= i_cfg_data[31:16];
                    r_coef.ac4 <= i_cfg_data[15:0];
                end
                bpc_pkg::REG_AC5_AC6: begin
                    r_coef.ac5 <= i_cfg_data[31:16];
                    r_coef.ac6 <= i_cfg_data[15:0];
                end
                bpc_pkg::REG_B1_B2: begin
                    r_coef.b1 <= i_cfg_data[31:16];
                    r_coef.b2 <= i_cfg_data[15:0];
                end
                bpc_pkg::REG_MC_MD: begin
                    r_coef.mc <= i_cfg_data[31:16];
                    r_coef.md <= i_cfg_data[15:0];
                end
                bpc_pkg::REG_OSS: begin
                    r_coef.oss <= i_cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !r_f_v || !i_q_full;
    assign w_take     = i_s_tvalid && o_s_tready;

    // (UT - AC6) * AC5, kept modulo 2^32.
    assign w_diff = {1'b0, i_s_tdata[15:0]} - {1'b0, r_coef.ac6};
    assign w_prod = {{17{w_diff[16]}}, w_diff} * {18'd0, r_coef.ac5};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_take) begin
            r_f_v <= 1'b1;
        end else if (!i_q_full) begin
            r_f_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prod <= w_prod[31:0];
            r_up   <= i_s_tdata[34:16];
        end
    end

    assign w_x1          = bpc_pkg::sdiv_p2(r_prod, 15);
    assign o_q_wr.push   = r_f_v && !i_q_full;
    assign o_q_wr.item.x1  = w_x1;
    assign o_q_wr.item.den = w_x1 + bpc_pkg::sx16(r_coef.md);
    assign o_q_wr.item.up  = r_up;

endmodule

// ===== rtl/bpc_back.sv =====
// ----------------------------------------------------------------------------
// bpc_back
// Stalling compensation pipeline with two dividers and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpc_pkg::t_coef  i_coef,
    input  logic            i_q_empty,
    input  bpc_pkg::t_fq    i_q_head,
    output logic            o_q_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [39:0]     o_m_tdata,   // temperature_tenths[15:0], pressure_pa[36:16]
    output logic            o_m_tuser    // divide_fault
);

    localparam int unsigned T1 = 1 + bpc_pkg::DIV_STAGES;
    localparam int unsigned D2 = T1 + 7;
    localparam int unsigned P1 = D2 + bpc_pkg::DIV_STAGES;

    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic        neg;
        logic        zt;
    } t_side1;

    typedef struct packed {
        logic [31:0] t;
        logic        flt;
        logic        big;
    } t_side2;

    logic                           w_adv;
    logic [bpc_pkg::BACK_STAGES-1:0] r_vld;
    logic                           r_out_v;
    logic [15:0]                    r_out_t;
    logic [20:0]                    r_out_p;
    logic                           r_out_flt;

    // Stage B0: operands of the temperature divider.
    logic [31:0] w_num_s;
    logic [31:0] r_b0_num;
    logic [31:0] r_b0_den;
    t_side1      r_b0_side;
    t_side1      r_s1 [bpc_pkg::DIV_STAGES];
    logic [31:0] w_q1;

    // Temperature tail and pressure scaling stages.
    logic [31:0] w_x2;
    logic [31:0] w_b5;
    logic [31:0] r_t1_t,   r_t1_b6;
    logic [18:0] r_t1_up;
    logic        r_t1_zt;
    logic [31:0] r_t2_t,   r_t2_sqp, r_t2_a2, r_t2_a3;
    logic [18:0] r_t2_up;
    logic        r_t2_zt;
    logic [31:0] r_t3_t,   r_t3_sq,  r_t3_x2, r_t3_x1c;
    logic [18:0] r_t3_up;
    logic        r_t3_zt;
    logic [31:0] r_t4_t,   r_t4_p1,  r_t4_p2, r_t4_x2, r_t4_x1c;
    logic [18:0] r_t4_up;
    logic        r_t4_zt;
    logic [31:0] w_x3,     w_bb,     w_x3b;
    logic [31:0] r_t5_t,   r_t5_b3,  r_t5_s;
    logic [18:0] r_t5_up;
    logic        r_t5_zt;
    logic [31:0] r_t6_t,   r_t6_b4,  r_t6_dif;
    logic        r_t6_zt;
    logic [31:0] r_t7_t,   r_t7_b4,  r_t7_b7;
    logic        r_t7_flt;
    t_side2      r_s2 [bpc_pkg::DIV_STAGES];
    logic [31:0] w_num2;
    logic [31:0] w_q2;

    // Pressure polynomial stages.
    logic [31:0] w_p;
    logic [31:0] w_a;
    logic [31:0] r_p1_p,   r_p1_aa,  r_p1_m,  r_p1_t;
    logic        r_p1_flt;
    logic [31:0] r_p2_p,   r_p2_x1,  r_p2_x2, r_p2_t;
    logic        r_p2_flt;
    logic [31:0] w_pn;

    assign w_adv   = !r_out_v || i_m_tready;
    assign o_q_pop = w_adv && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_vld   <= {r_vld[bpc_pkg::BACK_STAGES-2:0], !i_q_empty};
            r_out_v <= r_vld[bpc_pkg::BACK_STAGES-1];
        end
    end

    assign w_num_s = {{5{i_coef.mc[15]}}, i_coef.mc, 11'd0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b0_num       <= w_num_s[31] ? (32'd0 - w_num_s) : w_num_s;
            r_b0_den       <= i_q_head.den[31] ? (32'd0 - i_q_head.den) : i_q_head.den;
            r_b0_side.x1   <= i_q_head.x1;
            r_b0_side.up   <= i_q_head.up;
            r_b0_side.neg  <= w_num_s[31] ^ i_q_head.den[31];
            r_b0_side.zt   <= (i_q_head.den == 32'd0);
            r_s1[0]        <= r_b0_side;
            for (int i = 1; i < bpc_pkg::DIV_STAGES; i++) begin
                r_s1[i] <= r_s1[i-1];
            end
        end
    end

    bpc_div u_div_t (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_b0_num),
        .i_den (r_b0_den),
        .o_quo (w_q1)
    );

    assign w_x2  = r_s1[bpc_pkg::DIV_STAGES-1].neg ? (32'd0 - w_q1) : w_q1;
    assign w_b5  = r_s1[bpc_pkg::DIV_STAGES-1].x1 + w_x2;
    assign w_x3  = bpc_pkg::sdiv_p2(r_t4_p1, 11) + r_t4_x2;
    assign w_bb  = (bpc_pkg::sx16(i_coef.ac1) << 2) + w_x3;
    assign w_x3b = bpc_pkg::sdiv_p2(r_t4_x1c + bpc_pkg::sdiv_p2(r_t4_p2, 16) + 32'd2, 2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // B5, temperature and B6.
            r_t1_t   <= bpc_pkg::sdiv_p2(w_b5 + 32'd8, 4);
            r_t1_b6  <= w_b5 - bpc_pkg::C_B6_OFS;
            r_t1_up  <= r_s1[bpc_pkg::DIV_STAGES-1].up;
            r_t1_zt  <= r_s1[bpc_pkg::DIV_STAGES-1].zt;

            r_t2_t   <= r_t1_t;
            r_t2_sqp <= bpc_pkg::wmul(r_t1_b6, r_t1_b6);
            r_t2_a2  <= bpc_pkg::wmul(bpc_pkg::sx16(i_coef.ac2), r_t1_b6);
            r_t2_a3  <= bpc_pkg::wmul(bpc_pkg::sx16(i_coef.ac3), r_t1_b6);
            r_t2_up  <= r_t1_up;
            r_t2_zt  <= r_t1_zt;

            r_t3_t   <= r_t2_t;
            r_t3_sq  <= bpc_pkg::sdiv_p2(r_t2_sqp, 12);
            r_t3_x2  <= bpc_pkg::sdiv_p2(r_t2_a2, 11);
            r_t3_x1c <= bpc_pkg::sdiv_p2(r_t2_a3, 13);
            r_t3_up  <= r_t2_up;
            r_t3_zt  <= r_t2_zt;

            r_t4_t   <= r_t3_t;
            r_t4_p1  <= bpc_pkg::wmul(bpc_pkg::sx16(i_coef.b2), r_t3_sq);
            r_t4_p2  <= bpc_pkg::wmul(bpc_pkg::sx16(i_coef.b1), r_t3_sq);
            r_t4_x2  <= r_t3_x2;
            r_t4_x1c <= r_t3_x1c;
            r_t4_up  <= r_t3_up;
            r_t4_zt  <= r_t3_zt;

            // B3 and the scaled B4 operand.
            r_t5_t   <= r_t4_t;
            r_t5_b3  <= bpc_pkg::sdiv_p2((w_bb << i_coef.oss) + 32'd2, 2);
            r_t5_s   <= w_x3b + bpc_pkg::C_B4_OFS;
            r_t5_up  <= r_t4_up;
            r_t5_zt  <= r_t4_zt;

            r_t6_t   <= r_t5_t;
            r_t6_b4  <= bpc_pkg::wmul(bpc_pkg::zx16(i_coef.ac4), r_t5_s) >> 15;
            r_t6_dif <= {13'd0, r_t5_up} - r_t5_b3;
            r_t6_zt  <= r_t5_zt;

            r_t7_t   <= r_t6_t;
            r_t7_b4  <= r_t6_b4;
            r_t7_b7  <= bpc_pkg::wmul(r_t6_dif, bpc_pkg::C_B7_SCALE >> i_coef.oss);
            r_t7_flt <= r_t6_zt || (r_t6_b4 == 32'd0);

            r_s2[0].t   <= r_t7_t;
            r_s2[0].flt <= r_t7_flt;
            r_s2[0].big <= r_t7_b7[31];
            for (int i = 1; i < bpc_pkg::DIV_STAGES; i++) begin
                r_s2[i] <= r_s2[i-1];
            end
        end
    end

    // Below 2^31 the doubling goes before the division, else after it.
    assign w_num2 = r_t7_b7[31] ? r_t7_b7 : {r_t7_b7[30:0], 1'b0};

    bpc_div u_div_p (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_num2),
        .i_den (r_t7_b4),
        .o_quo (w_q2)
    );

    assign w_p  = r_s2[bpc_pkg::DIV_STAGES-1].big ? {w_q2[30:0], 1'b0} : w_q2;
    assign w_a  = bpc_pkg::sdiv_p2(w_p, 8);
    assign w_pn = r_p2_p + bpc_pkg::sdiv_p2(bpc_pkg::sdiv_p2(r_p2_x1, 16) + r_p2_x2
                  + bpc_pkg::C_P_K3, 4);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_p   <= w_p;
            r_p1_aa  <= bpc_pkg::wmul(w_a, w_a);
            r_p1_m   <= bpc_pkg::wmul(bpc_pkg::C_P_K2, w_p);
            r_p1_t   <= r_s2[bpc_pkg::DIV_STAGES-1].t;
            r_p1_flt <= r_s2[bpc_pkg::DIV_STAGES-1].flt;

            r_p2_p   <= r_p1_p;
            r_p2_x1  <= bpc_pkg::wmul(r_p1_aa, bpc_pkg::C_P_K1);
            r_p2_x2  <= bpc_pkg::sdiv_p2(r_p1_m, 16);
            r_p2_t   <= r_p1_t;
            r_p2_flt <= r_p1_flt;

            r_out_flt <= r_p2_flt;
            r_out_t   <= r_p2_flt ? 16'd0 : bpc_pkg::clamp_t(r_p2_t);
            r_out_p   <= r_p2_flt ? 21'd0 : bpc_pkg::clamp_p(w_pn);
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {3'd0, r_out_p, r_out_t};
    assign o_m_tuser  = r_out_flt;

    `CHK_SAME(a_b_fault, r_out_v && r_out_flt, (r_out_t == 16'd0) && (r_out_p == 21'd0), "fault result carries data")
    `CHK_NEXT(a_b_load, w_adv && r_vld[P1+1], r_out_v, "finished item not presented")
    `CHK_NEXT(a_b_hold, r_out_v && !i_m_tready, r_out_v, "stalled result dropped")

endmodule

// ===== rtl/barometric_pressure_compensation.sv =====
// Throughput: one reading pair per cycle while the output is not stalled;
// two 32-stage pipelined dividers set the depth.
// A four-entry queue lets the intake run on while the result side is stalled.
// Reset (i_rst_n low at a clock edge) clears all calibration words, the queue
// and every valid flag; data registers keep their contents.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // temperature_tenths[15:0], pressure_pa[36:16]
    output logic        o_m_tuser    // divide_fault
);

    bpc_pkg::t_coef  w_coef;
    bpc_pkg::t_fq_wr w_q_wr;
    bpc_pkg::t_fq    w_q_head;
    logic            w_q_full;
    logic            w_q_empty;
    logic            w_q_pop;

    bpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr),
        .o_coef      (w_coef)
    );

    bpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    bpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef     (w_coef),
        .i_q_empty  (w_q_empty),
        .i_q_head   (w_q_head),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
